// ----- hw/rtl/abb_pkg.sv -----
// abb_pkg: shared types, constants and helper functions for the affine bounding box
// used by abb_front, abb_queue, abb_back and affine_bounding_box
`timescale 1ns / 1ps
`default_nettype none

package abb_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned REG_IDX_W   = 3;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SCALE_X     = 3'd0,
    REG_SKEW_Y      = 3'd1,
    REG_SKEW_X      = 3'd2,
    REG_SCALE_Y     = 3'd3,
    REG_TRANSLATE_X = 3'd4,
    REG_TRANSLATE_Y = 3'd5
  } abb_reg_e;

  typedef struct packed {
    logic signed [31:0] scale_x;
    logic signed [31:0] skew_y;
    logic signed [31:0] skew_x;
    logic signed [31:0] scale_y;
  } abb_matrix_t;

  typedef struct packed {
    logic signed [31:0] translate_x;
    logic signed [31:0] translate_y;
  } abb_offset_t;

  // one mapped item as it travels from the front to the back
  typedef struct packed {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic               present;
    logic               last;
  } abb_entry_t;

  typedef struct packed {
    logic signed [31:0] box_left;
    logic signed [31:0] box_top;
    logic signed [31:0] box_right;
    logic signed [31:0] box_bottom;
  } abb_box_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'(S32_MAX)) begin
      r = S32_MAX;
    end else if (v < 65'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/abb_front.sv -----
// abb_front: input handshake and two-stage affine map of each point
// depends on abb_pkg; pushes mapped entries into abb_queue
`timescale 1ns / 1ps
`default_nettype none

module abb_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [63:0]                   s_axis_tdata,
  input  wire logic                          s_axis_tuser,
  input  wire logic                          s_axis_tlast,
  input  wire abb_pkg::abb_matrix_t          matrix,
  input  wire logic [abb_pkg::QCNT_W-1:0]    q_count,
  output      logic                          push,
  output      abb_pkg::abb_entry_t           push_entry
);

  logic               v1;
  logic               present1;
  logic               last1;
  logic signed [63:0] p_ax;
  logic signed [63:0] p_cy;
  logic signed [63:0] p_bx;
  logic signed [63:0] p_dy;
  logic               v2;
  abb_pkg::abb_entry_t entry2;

  logic signed [31:0] px;
  logic signed [31:0] py;
  logic               accept;
  logic [abb_pkg::QCNT_W:0] committed;
  logic signed [64:0] sum_x;
  logic signed [64:0] sum_y;

  assign px = s_axis_tdata[31:0];
  assign py = s_axis_tdata[63:32];

  // credit check: queue entries plus transactions still in the pipeline
  assign committed = (abb_pkg::QCNT_W+1)'(q_count)
                   + (abb_pkg::QCNT_W+1)'(v1)
                   + (abb_pkg::QCNT_W+1)'(v2);
  assign s_axis_tready = committed < (abb_pkg::QCNT_W+1)'(abb_pkg::QUEUE_DEPTH);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  // stage 1: four full products
  always_ff @(posedge clk) begin
    present1 <= s_axis_tuser;
    last1    <= s_axis_tlast;
    p_ax     <= 64'(px) * 64'(matrix.scale_x);
    p_cy     <= 64'(py) * 64'(matrix.skew_x);
    p_bx     <= 64'(px) * 64'(matrix.skew_y);
    p_dy     <= 64'(py) * 64'(matrix.scale_y);
  end

  // stage 2: floor shift, sum, saturate
  always_comb begin
    sum_x = ($signed({p_ax[63], p_ax}) >>> abb_pkg::FRAC_BITS)
          + ($signed({p_cy[63], p_cy}) >>> abb_pkg::FRAC_BITS);
    sum_y = ($signed({p_bx[63], p_bx}) >>> abb_pkg::FRAC_BITS)
          + ($signed({p_dy[63], p_dy}) >>> abb_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    entry2.mx      <= abb_pkg::sat32(sum_x);
    entry2.my      <= abb_pkg::sat32(sum_y);
    entry2.present <= present1;
    entry2.last    <= last1;
  end

  assign push       = v2;
  assign push_entry = entry2;

endmodule

`default_nettype wire

// ----- hw/rtl/abb_queue.sv -----
// abb_queue: short fifo of mapped entries between front and back
// depends on abb_pkg
`timescale 1ns / 1ps
`default_nettype none

module abb_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire abb_pkg::abb_entry_t        push_entry,
  input  wire logic                       pop,
  output      logic                       head_valid,
  output      abb_pkg::abb_entry_t        head,
  output      logic [abb_pkg::QCNT_W-1:0] count
);

  abb_pkg::abb_entry_t             slots [abb_pkg::QUEUE_DEPTH];
  logic [abb_pkg::QPTR_W-1:0]      wr_ptr;
  logic [abb_pkg::QPTR_W-1:0]      rd_ptr;

  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != abb_pkg::QCNT_W'(abb_pkg::QUEUE_DEPTH)) || pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/abb_back.sv -----
// abb_back: running min/max of mapped points, translation and result register
// depends on abb_pkg; drains abb_queue and drives the master stream
`timescale 1ns / 1ps
`default_nettype none

module abb_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 head_valid,
  input  wire abb_pkg::abb_entry_t  head,
  output      logic                 pop,
  input  wire abb_pkg::abb_offset_t offset,
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      abb_pkg::abb_box_t    box
);

  logic signed [31:0] least_x;
  logic signed [31:0] least_y;
  logic signed [31:0] greatest_x;
  logic signed [31:0] greatest_y;
  logic               any_seen;

  logic signed [31:0] least_x_next;
  logic signed [31:0] least_y_next;
  logic signed [31:0] greatest_x_next;
  logic signed [31:0] greatest_y_next;
  logic               any_seen_next;
  logic               out_free;
  abb_pkg::abb_box_t  box_next;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  // a closing entry waits until the result register can take it
  assign pop = head_valid && (!head.last || out_free);

  always_comb begin
    least_x_next    = least_x;
    least_y_next    = least_y;
    greatest_x_next = greatest_x;
    greatest_y_next = greatest_y;
    any_seen_next   = any_seen || head.present;
    if (head.present) begin
      if (head.mx < least_x)    least_x_next    = head.mx;
      if (head.mx > greatest_x) greatest_x_next = head.mx;
      if (head.my < least_y)    least_y_next    = head.my;
      if (head.my > greatest_y) greatest_y_next = head.my;
    end
    if (any_seen_next) begin
      box_next.box_left   = abb_pkg::sat32(65'(least_x_next) + 65'(offset.translate_x));
      box_next.box_top    = abb_pkg::sat32(65'(least_y_next) + 65'(offset.translate_y));
      box_next.box_right  = abb_pkg::sat32(65'(greatest_x_next) + 65'(offset.translate_x));
      box_next.box_bottom = abb_pkg::sat32(65'(greatest_y_next) + 65'(offset.translate_y));
    end else begin
      box_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      least_x    <= abb_pkg::S32_MAX;
      least_y    <= abb_pkg::S32_MAX;
      greatest_x <= abb_pkg::S32_MIN;
      greatest_y <= abb_pkg::S32_MIN;
      any_seen   <= 1'b0;
    end else if (pop) begin
      if (head.last) begin
        least_x    <= abb_pkg::S32_MAX;
        least_y    <= abb_pkg::S32_MAX;
        greatest_x <= abb_pkg::S32_MIN;
        greatest_y <= abb_pkg::S32_MIN;
        any_seen   <= 1'b0;
      end else begin
        least_x    <= least_x_next;
        least_y    <= least_y_next;
        greatest_x <= greatest_x_next;
        greatest_y <= greatest_y_next;
        any_seen   <= any_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop && head.last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      box <= box_next;
    end
  end

`ifndef SYNTH
  a_result_from_close: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(pop && head.last))
    else $error("result raised without a closing entry");

  a_clear_after_close: assert property (@(posedge clk) disable iff (rst)
    (pop && head.last) |=> !any_seen && (least_x == abb_pkg::S32_MAX))
    else $error("running box not cleared after close");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/affine_bounding_box.sv -----
// affine_bounding_box: top level, configuration registers and module wiring
// depends on abb_pkg, abb_front, abb_queue, abb_back
//
// usage:
//   slave stream carries one point per transaction: tdata holds point_x in
//   bits 31:0 and point_y in bits 63:32 (Q16.16 signed), tuser says a point is
//   present, tlast closes the set. the master stream carries one box per closed
//   set: tdata holds box_left, box_top, box_right, box_bottom from bit 0 up.
//   the matrix and translation are written through cfg_we/cfg_index/cfg_data
//   while no set is in flight; index 0..5 follow scale_x, skew_y, skew_x,
//   scale_y, translate_x, translate_y, higher indexes are dropped.
//   throughput is one transaction per cycle while s_axis_tready is high. a box
//   shows on the master side once its closing transaction has been through
//   these steps: the products are taken at the accepting edge, then shift and
//   sum, the queue write and the min/max and translate step in the back.
//   a four-entry queue sits between them; the slave side stalls only when the
//   queue plus the two front stages hold four transactions, i.e. when the
//   receiver holds m_axis_tready low with a box pending and more sets close
//   behind it.
//   reset restores the default identity matrix, zero translation and an
//   empty running box; an empty set yields an all-zero box.
`timescale 1ns / 1ps
`default_nettype none

module affine_bounding_box (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  input  wire logic [63:0]                     s_axis_tdata,  // point_x, point_y
  input  wire logic                            s_axis_tuser,  // point_present
  input  wire logic                            s_axis_tlast,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // box_left, box_top, box_right, box_bottom
  output      logic [127:0]                    m_axis_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [abb_pkg::REG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                     cfg_data
);

  abb_pkg::abb_matrix_t            matrix;
  abb_pkg::abb_offset_t            offset;
  logic                            push;
  abb_pkg::abb_entry_t             push_entry;
  logic                            pop;
  logic                            head_valid;
  abb_pkg::abb_entry_t             head;
  logic [abb_pkg::QCNT_W-1:0]      q_count;
  abb_pkg::abb_box_t               box;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix.scale_x     <= 32'sd65536;
      matrix.skew_y      <= '0;
      matrix.skew_x      <= '0;
      matrix.scale_y     <= 32'sd65536;
      offset.translate_x <= '0;
      offset.translate_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        abb_pkg::REG_SCALE_X:     matrix.scale_x     <= cfg_data;
        abb_pkg::REG_SKEW_Y:      matrix.skew_y      <= cfg_data;
        abb_pkg::REG_SKEW_X:      matrix.skew_x      <= cfg_data;
        abb_pkg::REG_SCALE_Y:     matrix.scale_y     <= cfg_data;
        abb_pkg::REG_TRANSLATE_X: offset.translate_x <= cfg_data;
        abb_pkg::REG_TRANSLATE_Y: offset.translate_y <= cfg_data;
        default: ;
      endcase
    end
  end

  abb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .matrix        (matrix),
    .q_count       (q_count),
    .push          (push),
    .push_entry    (push_entry)
  );

  abb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  abb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .offset        (offset),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .box           (box)
  );

  assign m_axis_tdata = {box.box_bottom, box.box_right, box.box_top, box.box_left};

endmodule

`default_nettype wire
